@@ sv/ifct_pkg.sv @@
// ifct_pkg: shared types, constants and codes for the fragment context tracker
// no dependencies
`default_nettype none
package ifct_pkg;
  localparam int CONTEXTS_DEF = 16;
  localparam int CTX_IDX_W = 6;
  localparam logic [16:0] COLLECT_MAX = 17'h1FFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd30;
  localparam logic [16:0] MAX_BYTES_RST = 17'd65535;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_COMPLETE = 3'd1,
    EV_OVERRUN  = 3'd2,
    EV_OVERSIZE = 3'd3,
    EV_EXPIRED  = 3'd4,
    EV_FULL     = 3'd5
  } event_t;

  typedef enum logic [0:0] {
    CFG_TIMEOUT   = 1'b0,
    CFG_MAX_BYTES = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MATCH, ST_UPDATE, ST_REPORT, ST_SCAN
  } state_t;

  typedef struct packed {
    logic        op;
    logic [15:0] frag_id;
    logic [31:0] src_addr;
    logic [7:0]  proto;
    logic [15:0] flags_offset;
    logic [15:0] total_len;
    logic [3:0]  header_words;
    logic [15:0] payload_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [5:0]  context_res;
    logic [7:0]  frag_count;
    logic [16:0] datagram_bytes;
    logic        last;
  } out_item_t;

  // one context entry
  typedef struct packed {
    logic        valid;
    logic [55:0] key;
    logic [16:0] collected;
    logic        req_known;
    logic [16:0] required;
    logic [16:0] max_end;
    logic [7:0]  count;
    logic [31:0] start_time;
  } ctx_t;

  // control from sequencer to each cell
  typedef struct packed {
    logic        do_write;
    logic        do_clear;
  } cell_ctl_t;
endpackage
`default_nettype wire

@@ sv/ifct_cell.sv @@
// ifct_cell: one context slot; holds its entry and passes the hit and free chain bits to its neighbor
// depends on ifct_pkg
`default_nettype none
module ifct_cell
  import ifct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [55:0] key_i,
  input  wire logic      hit_i,      // a lower cell already matched
  output logic           hit_o,
  input  wire logic      free_i,     // a lower cell already free
  output logic           free_o,
  output logic           match_o,
  output logic           empty_o,
  input  wire cell_ctl_t ctl_i,
  input  wire ctx_t      wr_i,
  output ctx_t           ent_o
);
  ctx_t ent_r;
  logic valid_r;

  assign match_o = valid_r && (ent_r.key == key_i);
  assign empty_o = !valid_r;
  assign hit_o   = hit_i || match_o;
  assign free_o  = free_i || !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.do_write) begin
      valid_r <= wr_i.valid;
    end else if (ctl_i.do_clear) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.do_write) begin
      ent_r <= wr_i;
    end
  end

  always_comb begin
    ent_o = ent_r;
    ent_o.valid = valid_r;
  end
endmodule
`default_nettype wire

@@ sv/ipv4_fragment_context_tracker_top.sv @@
// fragment context tracker: an arrival passes through capture, match, update and report;
// a tick scans every cell in turn, one cell visited per cycle in the scan,
// and when the top slot expires its strobe lands after the scan
// busy is high from acceptance to the last result strobe; results cannot be stalled
// synchronous active-low reset empties every context and zeroes the tick counter
// depends on ifct_pkg, ifct_cell
`default_nettype none
module ipv4_fragment_context_tracker_top
  import ifct_pkg::*;
#(
  parameter int CONTEXTS = CONTEXTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int IW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

  state_t    state_r, state_nxt;
  in_item_t  item_r;
  logic [15:0] timeout_r;
  logic [16:0] max_bytes_r;
  logic [31:0] now_r;
  logic [IW-1:0] slot_r;
  logic [IW-1:0] scan_r;
  logic        found_r;
  out_item_t out_r;
  logic      out_valid_r;

  // a transaction is taken only while idle and no strobe is pending
  logic accept;
  assign accept = start && !busy;

  // per-cell wiring: hit/free chains run up the row
  logic [CONTEXTS:0] hit_ch, free_ch;
  logic [CONTEXTS-1:0] match_v, empty_v;
  ctx_t ents [CONTEXTS];
  cell_ctl_t ctls [CONTEXTS];
  ctx_t wr_ent;

  logic [55:0] key;
  assign key = {item_r.frag_id, item_r.src_addr, item_r.proto};
  assign hit_ch[0]  = 1'b0;
  assign free_ch[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CONTEXTS; g++) begin : g_cell
      ifct_cell u_cell (
        .clk(clk), .rst_n(rst_n), .key_i(key),
        .hit_i(hit_ch[g]), .hit_o(hit_ch[g+1]),
        .free_i(free_ch[g]), .free_o(free_ch[g+1]),
        .match_o(match_v[g]), .empty_o(empty_v[g]),
        .ctl_i(ctls[g]), .wr_i(wr_ent), .ent_o(ents[g])
      );
    end
  endgenerate

  // lowest matching / lowest free slot (priority by the loop, lowest index wins)
  logic [IW-1:0] match_idx, free_idx;
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (match_v[i]) match_idx = IW'(i);
      if (empty_v[i]) free_idx  = IW'(i);
    end
  end

  // fragment arithmetic
  logic        mf;
  logic [18:0] end_full;
  logic        end_neg, end_pos;
  logic [16:0] end_v;
  assign mf = item_r.flags_offset[13];
  always_comb begin
    end_full = {3'b0, item_r.flags_offset[12:0], 3'b0} + {3'b0, item_r.total_len}
             - {13'b0, item_r.header_words, 2'b0};
  end
  assign end_neg = end_full[18];
  assign end_pos = !end_neg && (end_full != '0);
  assign end_v   = end_full[16:0];

  ctx_t cur, upd;
  logic [17:0] coll_sum;
  logic        finish;
  event_t      ev;
  always_comb begin
    cur = ents[slot_r];
    upd = cur;
    // a new context when there was no match
    if (!found_r) begin
      upd.key = key; upd.collected = '0; upd.req_known = 1'b0;
      upd.required = '0; upd.max_end = '0; upd.count = '0;
      upd.start_time = now_r;
    end
    upd.valid = 1'b1;
    coll_sum = {1'b0, upd.collected} + {2'b0, item_r.payload_bytes};
    upd.collected = coll_sum[17] ? COLLECT_MAX : coll_sum[16:0];
    if (upd.count != 8'hFF) upd.count = upd.count + 8'd1;
    if (end_pos && (end_v > upd.max_end)) upd.max_end = end_v;
    if (!mf) begin
      upd.req_known = !end_neg;
      upd.required  = end_neg ? 17'd0 : end_v;
    end
    finish = upd.req_known && (upd.collected == upd.required);
    ev = EV_QUEUED;
    if (finish) begin
      if (upd.required > max_bytes_r)     ev = EV_OVERSIZE;
      else if (upd.max_end > upd.required) ev = EV_OVERRUN;
      else                                 ev = EV_COMPLETE;
      upd.valid = 1'b0;
    end
  end
  assign wr_ent = upd;

  // scan side
  ctx_t    sc;
  logic [31:0] age;
  logic    sc_exp;
  logic    scan_done;
  assign sc        = ents[scan_r];
  assign age       = now_r - sc.start_time;
  assign sc_exp    = sc.valid && (age > {16'b0, timeout_r});
  assign scan_done = (scan_r == IW'(CONTEXTS - 1));

  logic   in_found, in_full;
  assign in_found = hit_ch[CONTEXTS];
  assign in_full  = !in_found && !free_ch[CONTEXTS];
  logic full_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = in_item.op ? ST_SCAN : ST_MATCH;
      ST_MATCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      ST_SCAN:   if (scan_done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // cell controls
  always_comb begin
    for (int i = 0; i < CONTEXTS; i++) begin
      ctls[i].do_write = (state_r == ST_UPDATE) && !full_r && (slot_r == IW'(i));
      ctls[i].do_clear = (state_r == ST_SCAN) && sc_exp && (scan_r == IW'(i));
    end
  end

  // look ahead: any expiry above the current scan slot, for last flag
  logic more_exp;
  always_comb begin
    more_exp = 1'b0;
    for (int i = 0; i < CONTEXTS; i++) begin
      if (IW'(i) > scan_r && ents[i].valid &&
          ((now_r - ents[i].start_time) > {16'b0, timeout_r}))
        more_exp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timeout_r   <= TIMEOUT_RST;
      max_bytes_r <= MAX_BYTES_RST;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      slot_r      <= '0;
      found_r     <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIMEOUT:   timeout_r   <= cfg_data[15:0];
          CFG_MAX_BYTES: max_bytes_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_item.op) begin
            now_r  <= now_r + 32'd1;
            scan_r <= '0;
          end
        end
        ST_MATCH: begin
          found_r <= in_found;
          full_r  <= in_full;
          slot_r  <= in_found ? match_idx : free_idx;
        end
        ST_UPDATE: begin
          out_valid_r <= 1'b1;
          if (full_r) out_r <= '{event_res: EV_FULL, context_res: '0,
                                 frag_count: '0, datagram_bytes: '0, last: 1'b1};
          else out_r <= '{event_res: ev, context_res: CTX_IDX_W'(slot_r),
                          frag_count: upd.count,
                          datagram_bytes: upd.req_known ? upd.required : 17'd0,
                          last: 1'b1};
        end
        ST_SCAN: begin
          if (sc_exp) begin
            out_valid_r <= 1'b1;
            out_r <= '{event_res: EV_EXPIRED, context_res: CTX_IDX_W'(scan_r),
                       frag_count: sc.count,
                       datagram_bytes: sc.req_known ? sc.required : 17'd0,
                       last: !more_exp};
          end
          if (!scan_done) scan_r <= scan_r + IW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    item_r <= accept ? in_item : item_r;
  end

  assign busy      = (state_r != ST_IDLE) || out_valid_r;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

@@ sv/ifct_checker.sv @@
// ifct_checker: port-level checks for the tracker, bound to the top level
// depends on ifct_pkg
`default_nettype none
module ifct_checker
  import ifct_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_res == EV_FULL |-> out_item.context_res == '0 &&
      out_item.frag_count == '0 && out_item.last)
    else $error("full result not zeroed");
  a_arrive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.event_res <= EV_FULL)
    else $error("bad event code");
  a_nonexp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_res != EV_EXPIRED |-> out_item.last)
    else $error("arrival result without last");
endmodule

bind ipv4_fragment_context_tracker_top ifct_checker u_ifct_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
